// ===== sv/mtbk_pkg.sv =====
// Package for the two-button Morse keyer: transaction payload types, event and
// state codes, register indexes and the letter and digit code table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mtbk_pkg;

    localparam int C_MESSAGE_DEPTH      = 32;
    localparam int C_SYMBOLS_PER_CHAR   = 5;
    localparam int C_MAX_SYMBOLS        = 5;
    localparam int C_CODE_COUNT         = 36;
    localparam int C_PADDR_W            = 4;
    localparam int C_REM_W              = 9;
    localparam int C_REM_STEPS          = 9;

    localparam logic [15:0] C_LONG_PRESS_RESET = 16'd200;
    localparam logic [7:0]  C_OWN_ID_RESET     = 8'd1;
    localparam logic [7:0]  C_RECV_COUNT_RESET = 8'd6;
    localparam logic [6:0]  C_CHAR_UNKNOWN     = 7'h3F;

    localparam logic [1:0] C_REG_LONG_PRESS = 2'd0;
    localparam logic [1:0] C_REG_OWN_ID     = 2'd1;
    localparam logic [1:0] C_REG_RECV_COUNT = 2'd2;

    typedef enum logic [2:0] {
        EV_NONE = 3'd0,
        EV_DOT  = 3'd1,
        EV_DASH = 3'd2,
        EV_SAVE = 3'd3,
        EV_SEND = 3'd4,
        EV_BOTH = 3'd5
    } t_event;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_STATUS,
        ST_HDR_RECV,
        ST_HDR_OWN,
        ST_TEXT_RD,
        ST_TEXT_OUT
    } t_state;

    typedef struct packed {
        logic        button_a_down;
        logic        button_b_down;
        logic [31:0] time_ms;
    } t_in_item;

    typedef struct packed {
        logic [2:0] event_code;
        logic [6:0] decoded_char;
        logic [2:0] symbol_count;
        logic [5:0] message_length;
        logic [7:0] receiver_id;
        logic       packet_byte_valid;
        logic [7:0] packet_byte;
        logic       last_of_run;
    } t_out_item;

    typedef struct packed {
        logic [2:0] len;
        logic [4:0] bits;
        logic [6:0] ch;
    } t_code_entry;

    // Bit i holds symbol i, a dash is 1.
    localparam t_code_entry C_CODE_TABLE [C_CODE_COUNT] = '{
        '{3'd2, 5'h02, 7'h41}, '{3'd4, 5'h01, 7'h42}, '{3'd4, 5'h05, 7'h43},
        '{3'd3, 5'h01, 7'h44}, '{3'd1, 5'h00, 7'h45}, '{3'd4, 5'h04, 7'h46},
        '{3'd3, 5'h03, 7'h47}, '{3'd4, 5'h00, 7'h48}, '{3'd2, 5'h00, 7'h49},
        '{3'd4, 5'h0E, 7'h4A}, '{3'd3, 5'h05, 7'h4B}, '{3'd4, 5'h02, 7'h4C},
        '{3'd2, 5'h03, 7'h4D}, '{3'd2, 5'h01, 7'h4E}, '{3'd3, 5'h07, 7'h4F},
        '{3'd4, 5'h06, 7'h50}, '{3'd4, 5'h0B, 7'h51}, '{3'd3, 5'h02, 7'h52},
        '{3'd3, 5'h00, 7'h53}, '{3'd1, 5'h01, 7'h54}, '{3'd3, 5'h04, 7'h55},
        '{3'd4, 5'h08, 7'h56}, '{3'd3, 5'h06, 7'h57}, '{3'd4, 5'h09, 7'h58},
        '{3'd4, 5'h0D, 7'h59}, '{3'd4, 5'h03, 7'h5A},
        '{3'd5, 5'h1F, 7'h30}, '{3'd5, 5'h1E, 7'h31}, '{3'd5, 5'h1C, 7'h32},
        '{3'd5, 5'h18, 7'h33}, '{3'd5, 5'h10, 7'h34}, '{3'd5, 5'h00, 7'h35},
        '{3'd5, 5'h01, 7'h36}, '{3'd5, 5'h03, 7'h37}, '{3'd5, 5'h07, 7'h38},
        '{3'd5, 5'h0F, 7'h39}
    };

    function automatic logic [6:0] morse_decode(input logic [2:0] len,
                                                input logic [4:0] bits);
        logic [6:0] ch;
        ch = C_CHAR_UNKNOWN;
        for (int k = 0; k < C_CODE_COUNT; k++) begin
            if (C_CODE_TABLE[k].len == len && C_CODE_TABLE[k].bits == bits) begin
                ch = C_CODE_TABLE[k].ch;
            end
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

// ===== sv/morse_two_button_keyer.sv =====
// Top level of the two-button Morse keyer: APB register file, symbol buffer,
// message memory and the result sequencer. Depends on mtbk_pkg, mtbk_press
// and mtbk_rem.
//
// Each input transaction is one timestamped sample of buttons A and B. The
// block takes a sample only when it has delivered every result of the one
// before, yet a finished result may still wait in the output register.
// A sample that ends a both-buttons gesture first waits for the bit-serial
// remainder unit that wraps the receiver id. A send with stored characters
// adds two header bytes and each character, read through the single read
// port of the message memory, whose read data arrives the cycle after the
// address. Output stalls can hold any of these steps. There is no clearing
// pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module morse_two_button_keyer #(
    parameter int MESSAGE_DEPTH    = mtbk_pkg::C_MESSAGE_DEPTH,
    parameter int SYMBOLS_PER_CHAR = mtbk_pkg::C_SYMBOLS_PER_CHAR
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  mtbk_pkg::t_in_item                   i_in_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output mtbk_pkg::t_out_item                  o_out_data,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [mtbk_pkg::C_PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                     pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);
    import mtbk_pkg::*;

    localparam int FW = $clog2(MESSAGE_DEPTH + 1);
    localparam int AW = (MESSAGE_DEPTH > 1) ? $clog2(MESSAGE_DEPTH) : 1;
    localparam int SW = $clog2(SYMBOLS_PER_CHAR + 1);

    t_state                      r_state;
    t_state                      n_state;
    logic [15:0]                 r_long_press_ms;
    logic [7:0]                  r_own_id;
    logic [7:0]                  r_recv_count;
    logic [SYMBOLS_PER_CHAR-1:0] r_sym_bits;
    logic [SYMBOLS_PER_CHAR-1:0] n_sym_bits;
    logic [SW-1:0]               r_sym_fill;
    logic [SW-1:0]               n_sym_fill;
    logic [FW-1:0]               r_msg_fill;
    logic [FW-1:0]               n_msg_fill;
    logic [FW-1:0]               r_pkt_len;
    logic [FW-1:0]               n_pkt_len;
    logic [FW-1:0]               r_idx;
    logic [7:0]                  r_recv;
    t_event                      r_ev;
    logic [6:0]                  r_ch;
    logic [6:0]                  n_ch;
    logic [6:0]                  r_msg_mem [MESSAGE_DEPTH];
    logic [6:0]                  r_rd_data;
    logic                        r_out_valid;
    t_out_item                   r_out_data;
    t_event                      w_event;
    logic                        w_accept;
    logic                        w_slot;
    logic                        w_load;
    t_out_item                   w_out_next;
    logic                        w_cfg_write;
    logic                        w_mem_we;
    logic [4:0]                  w_sym_mask;
    logic [4:0]                  w_sym_pad;
    logic [6:0]                  w_decoded;
    logic                        w_last_text;
    logic                        w_rem_start;
    logic                        w_rem_done;
    logic [7:0]                  w_rem;
    logic [C_REM_W-1:0]          w_dividend;
    logic [C_REM_W-1:0]          w_divisor;

    assign w_accept    = i_in_valid && o_in_ready;
    assign w_slot      = !r_out_valid || i_out_ready;
    assign w_cfg_write = psel && penable && pwrite && pready;
    assign pready      = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign w_last_text = (r_idx == (r_pkt_len - FW'(1)));
    assign w_rem_start = w_accept && (w_event == EV_BOTH);
    assign w_dividend  = {1'b0, r_recv} + 9'd1;
    assign w_divisor   = {(r_recv_count == 8'd0), r_recv_count};

    mtbk_press u_press (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (w_accept),
        .i_item          (i_in_data),
        .i_long_press_ms (r_long_press_ms),
        .o_event         (w_event)
    );

    mtbk_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_rem_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_rem_done),
        .o_rem      (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_press_ms <= C_LONG_PRESS_RESET;
            r_own_id        <= C_OWN_ID_RESET;
            r_recv_count    <= C_RECV_COUNT_RESET;
        end else if (w_cfg_write) begin
            unique case (paddr[3:2])
                C_REG_LONG_PRESS: r_long_press_ms <= pwdata[15:0];
                C_REG_OWN_ID:     r_own_id        <= pwdata[7:0];
                C_REG_RECV_COUNT: r_recv_count    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            C_REG_LONG_PRESS: prdata = {16'd0, r_long_press_ms};
            C_REG_OWN_ID:     prdata = {24'd0, r_own_id};
            C_REG_RECV_COUNT: prdata = {24'd0, r_recv_count};
            default:          prdata = '0;
        endcase
    end

    always_comb begin
        for (int k = 0; k < 5; k++) begin
            w_sym_mask[k] = (3'(k) < 3'(r_sym_fill));
        end
        w_sym_pad = 5'(r_sym_bits) & w_sym_mask;
        w_decoded = morse_decode(3'(r_sym_fill), w_sym_pad);
    end

    always_comb begin
        n_sym_bits = r_sym_bits;
        n_sym_fill = r_sym_fill;
        n_msg_fill = r_msg_fill;
        n_pkt_len  = '0;
        n_ch       = '0;
        w_mem_we   = 1'b0;
        case (w_event) inside
            EV_DOT, EV_DASH: begin
                if (r_sym_fill < SW'(SYMBOLS_PER_CHAR)) begin
                    for (int k = 0; k < SYMBOLS_PER_CHAR; k++) begin
                        if (r_sym_fill == SW'(k)) begin
                            n_sym_bits[k] = (w_event == EV_DASH);
                        end
                    end
                    n_sym_fill = r_sym_fill + SW'(1);
                end
            end
            EV_SAVE: begin
                if (r_sym_fill != '0 && r_msg_fill < FW'(MESSAGE_DEPTH)) begin
                    n_ch       = w_decoded;
                    w_mem_we   = w_accept;
                    n_msg_fill = r_msg_fill + FW'(1);
                    n_sym_fill = '0;
                end
            end
            EV_SEND: begin
                n_pkt_len  = r_msg_fill;
                n_msg_fill = '0;
                n_sym_fill = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sym_fill <= '0;
            r_msg_fill <= '0;
            r_recv     <= '0;
            r_idx      <= '0;
        end else begin
            if (w_accept) begin
                r_sym_fill <= n_sym_fill;
                r_msg_fill <= n_msg_fill;
                r_idx      <= '0;
            end else if (r_state == ST_TEXT_OUT && w_slot) begin
                r_idx <= r_idx + FW'(1);
            end
            if (r_state == ST_MOD && w_rem_done) begin
                r_recv <= w_rem;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sym_bits <= n_sym_bits;
            r_pkt_len  <= n_pkt_len;
            r_ev       <= w_event;
            r_ch       <= n_ch;
        end
    end

    // Writes happen only on a save, in the idle state, and read data is used only
    // while a send drains, so a write never meets a read whose data is used.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_msg_mem[r_msg_fill[AW-1:0]] <= w_decoded;
        end
        r_rd_data <= r_msg_mem[r_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = (w_event == EV_BOTH) ? ST_MOD : ST_STATUS;
                end
            end
            ST_MOD: begin
                if (w_rem_done) begin
                    n_state = ST_STATUS;
                end
            end
            ST_STATUS: begin
                if (w_slot) begin
                    n_state = (r_pkt_len != '0) ? ST_HDR_RECV : ST_IDLE;
                end
            end
            ST_HDR_RECV: begin
                if (w_slot) begin
                    n_state = ST_HDR_OWN;
                end
            end
            ST_HDR_OWN: begin
                if (w_slot) begin
                    n_state = ST_TEXT_RD;
                end
            end
            ST_TEXT_RD: begin
                n_state = ST_TEXT_OUT;
            end
            ST_TEXT_OUT: begin
                if (w_slot) begin
                    n_state = w_last_text ? ST_IDLE : ST_TEXT_RD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready                   = 1'b0;
        w_load                       = 1'b0;
        w_out_next.event_code        = r_ev;
        w_out_next.decoded_char      = '0;
        w_out_next.symbol_count      = 3'(r_sym_fill);
        w_out_next.message_length    = 6'(r_msg_fill);
        w_out_next.receiver_id       = r_recv;
        w_out_next.packet_byte_valid = 1'b0;
        w_out_next.packet_byte       = '0;
        w_out_next.last_of_run       = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
            end
            ST_STATUS: begin
                w_load                  = w_slot;
                w_out_next.decoded_char = r_ch;
                w_out_next.last_of_run  = (r_pkt_len == '0);
            end
            ST_HDR_RECV: begin
                w_load                       = w_slot;
                w_out_next.packet_byte_valid = 1'b1;
                w_out_next.packet_byte       = r_recv;
            end
            ST_HDR_OWN: begin
                w_load                       = w_slot;
                w_out_next.packet_byte_valid = 1'b1;
                w_out_next.packet_byte       = r_own_id;
            end
            ST_TEXT_OUT: begin
                w_load                       = w_slot;
                w_out_next.packet_byte_valid = 1'b1;
                w_out_next.packet_byte       = {1'b0, r_rd_data};
                w_out_next.last_of_run       = w_last_text;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_data <= w_out_next;
        end
    end

    a_fill_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_msg_fill <= FW'(MESSAGE_DEPTH)) && (r_sym_fill <= SW'(SYMBOLS_PER_CHAR)))
        else $error("symbol or message fill beyond its depth");

    a_text_in_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TEXT_OUT || r_state == ST_TEXT_RD) |-> (r_idx < r_pkt_len))
        else $error("text read past the captured message length");

    a_recv_wrapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MOD && w_rem_done) |=>
            ((r_recv_count == 8'd0) || (r_recv < r_recv_count)))
        else $error("receiver id left at or above the receiver count");

endmodule

`default_nettype wire

// ===== sv/mtbk_press.sv =====
// Button press tracker: holds press state and start times for both buttons
// and classifies each sample into one keyer event. Depends on mtbk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mtbk_press (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_fire,
    input  mtbk_pkg::t_in_item       i_item,
    input  wire logic [15:0]         i_long_press_ms,
    output mtbk_pkg::t_event         o_event
);
    import mtbk_pkg::*;

    logic        r_a_held;
    logic        r_b_held;
    logic        r_both;
    logic [31:0] r_a_start;
    logic [31:0] r_b_start;
    logic        n_a_held;
    logic        n_b_held;
    logic        n_both;
    logic        w_a;
    logic        w_b;
    logic        w_a_rel;
    logic        w_b_rel;
    logic [31:0] w_a_dt;
    logic [31:0] w_b_dt;
    logic        w_a_short;
    logic        w_b_short;

    assign w_a       = i_item.button_a_down;
    assign w_b       = i_item.button_b_down;
    assign w_a_rel   = !w_a && r_a_held;
    assign w_b_rel   = !w_b && r_b_held && !w_a_rel;
    assign w_a_dt    = i_item.time_ms - r_a_start;
    assign w_b_dt    = i_item.time_ms - r_b_start;
    assign w_a_short = w_a_dt < {16'd0, i_long_press_ms};
    assign w_b_short = w_b_dt < {16'd0, i_long_press_ms};

    always_comb begin
        o_event  = EV_NONE;
        n_a_held = w_a ? 1'b1 : r_a_held;
        n_b_held = w_b ? 1'b1 : r_b_held;
        n_both   = r_both || (w_a && w_b);
        if (w_a_rel) begin
            n_a_held = 1'b0;
            if (n_both) begin
                n_both  = w_b;
                o_event = w_b ? EV_BOTH : EV_NONE;
            end else begin
                o_event = w_a_short ? EV_DOT : EV_DASH;
            end
        end else if (w_b_rel) begin
            n_b_held = 1'b0;
            if (n_both) begin
                n_both  = w_a;
                o_event = w_a ? EV_BOTH : EV_NONE;
            end else begin
                o_event = w_b_short ? EV_SAVE : EV_SEND;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_held  <= 1'b0;
            r_b_held  <= 1'b0;
            r_both    <= 1'b0;
            r_a_start <= '0;
            r_b_start <= '0;
        end else if (i_fire) begin
            r_a_held <= n_a_held;
            r_b_held <= n_b_held;
            r_both   <= n_both;
            if (w_a && !r_a_held) begin
                r_a_start <= i_item.time_ms;
            end
            if (w_b && !r_b_held) begin
                r_b_start <= i_item.time_ms;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/mtbk_rem.sv =====
// Restoring remainder unit for the receiver id wrap, one dividend bit per
// cycle across the nine-bit dividend. Depends on mtbk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mtbk_rem (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [mtbk_pkg::C_REM_W-1:0]  i_dividend,
    input  wire logic [mtbk_pkg::C_REM_W-1:0]  i_divisor,
    output logic                               o_done,
    output logic [7:0]                         o_rem
);
    import mtbk_pkg::*;

    logic               r_busy;
    logic               r_done;
    logic [3:0]         r_cnt;
    logic [C_REM_W-1:0] r_dvd;
    logic [C_REM_W-1:0] r_dvs;
    logic [C_REM_W-1:0] r_rem;
    logic [C_REM_W-1:0] w_trial;
    logic [C_REM_W-1:0] w_next;

    assign w_trial = {r_rem[C_REM_W-2:0], r_dvd[C_REM_W-1]};
    assign w_next  = (w_trial >= r_dvs) ? (w_trial - r_dvs) : w_trial;
    assign o_done  = r_done;
    assign o_rem   = r_rem[7:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 4'(C_REM_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 4'd1;
                if (r_cnt == 4'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[C_REM_W-2:0], 1'b0};
            r_rem <= w_next;
        end
    end

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < r_dvs))
        else $error("partial remainder reached the divisor");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("done pulse without a running division");

    a_busy_ends_in_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_start && r_cnt == 4'd1) |=> r_done)
        else $error("last division step gave no done pulse");

endmodule

`default_nettype wire
